// File: hdl/sha1bsh_pkg.sv
`timescale 1ns / 1ps
package sha1bsh_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned BlockBits  = 512;
  localparam int unsigned LastRound  = 79;

  localparam logic [31:0] INIT_WORDS [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef struct packed {
    logic       push;
    logic       shift;
    logic [7:0] data;
  } blk_ctrl_t;

endpackage

// File: hdl/sha1bsh_round.sv
`timescale 1ns / 1ps
module sha1bsh_round (
  input  sha1bsh_pkg::work_t  cur_i,
  input  logic [31:0]         w_i,
  input  logic [6:0]          round_i,
  output sha1bsh_pkg::work_t  nxt_o
);
  import sha1bsh_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    if (round_i < 7'd20) begin
      f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      k = K_ROUND0;
    end else if (round_i < 7'd40) begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K_ROUND1;
    end else if (round_i < 7'd60) begin
      f = (cur_i.b & cur_i.c) | (cur_i.b & cur_i.d) | (cur_i.c & cur_i.d);
      k = K_ROUND2;
    end else begin
      f = cur_i.b ^ cur_i.c ^ cur_i.d;
      k = K_ROUND3;
    end
    tmp = {cur_i.a[26:0], cur_i.a[31:27]} + f + cur_i.e + k + w_i;
  end

  assign nxt_o.a = tmp;
  assign nxt_o.b = cur_i.a;
  assign nxt_o.c = {cur_i.b[1:0], cur_i.b[31:2]};
  assign nxt_o.d = cur_i.c;
  assign nxt_o.e = cur_i.d;

endmodule

// File: hdl/sha1bsh_block.sv
`timescale 1ns / 1ps
module sha1bsh_block (
  input  logic                   clk_i,
  input  sha1bsh_pkg::blk_ctrl_t ctrl_i,
  output logic [31:0]            w_o
);
  import sha1bsh_pkg::*;

  // Word j of the sixteen-word window sits at bits 511-32*j, word 0 in the highest bits.
  logic [BlockBits-1:0] blk_q;
  logic [31:0]          mix;
  logic [31:0]          w_new;

  assign w_o   = blk_q[511:480];
  assign mix   = blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32]
               ^ blk_q[511-32*2 -: 32] ^ blk_q[511:480];
  assign w_new = {mix[30:0], mix[31]};

  // Bytes enter at the bottom, so the block is big-endian once 64 are in.
  // During the rounds the window slides one word and the expanded word enters.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      blk_q <= {blk_q[BlockBits-9:0], ctrl_i.data};
    end else if (ctrl_i.shift) begin
      blk_q <= {blk_q[BlockBits-33:0], w_new};
    end
  end

endmodule

// File: hdl/sha1_byte_stream_hasher_core.sv
// SHA-1 hasher fed one message byte per item.
// Input channel s_axis: tdata[7:0] is the byte, tuser is set when the byte is
// present, tlast ends the message. Output channel m_axis: tdata is one 32-bit
// digest word, tuser its index 0 to 4, tlast marks the fifth word.
// A byte item is taken while the block is filling. The 64th byte
// of a block starts the compression: one round per cycle through a
// single round unit, then a fold of the result into the chain, during
// which s_axis_tready is low. After tlast the padding bytes go through the
// same byte path one per cycle while no compression runs (9 to 72 of them,
// plus an empty step before the length bytes) and cause one or two more
// compressions; then the five words are offered one at a time. A stalled
// receiver holds the current word and the block takes no input until the
// last word is taken, after which it returns to the initial chaining
// state. Reset (rst_ni low) loads the initial chaining values and clears
// the byte counts; the block is ready right after.
`timescale 1ns / 1ps
module sha1_byte_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha1bsh_pkg::*;

  state_e      state_q, state_d;
  pad_phase_e  phase_q, phase_d;
  logic        pad_q, pad_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] total_q, total_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] chain_q [NumWords];
  logic [31:0] chain_d [NumWords];
  work_t       work_q, work_d;
  work_t       round_nxt;
  blk_ctrl_t   blk_ctrl;
  logic [31:0] w_cur;
  logic        push_en;
  logic [7:0]  push_val;
  logic [63:0] total_inc;

  sha1bsh_block u_block (
    .clk_i  (clk_i),
    .ctrl_i (blk_ctrl),
    .w_o    (w_cur)
  );

  sha1bsh_round u_round (
    .cur_i   (work_q),
    .w_i     (w_cur),
    .round_i (rnd_q),
    .nxt_o   (round_nxt)
  );

  assign total_inc = total_q + 64'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MARK;
      pad_q   <= 1'b0;
      rnd_q   <= '0;
      fill_q  <= '0;
      total_q <= '0;
      lcnt_q  <= '0;
      oidx_q  <= '0;
      for (int i = 0; i < NumWords; i++) begin
        chain_q[i] <= INIT_WORDS[i];
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pad_q   <= pad_d;
      rnd_q   <= rnd_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      lcnt_q  <= lcnt_d;
      oidx_q  <= oidx_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    pad_d    = pad_q;
    rnd_d    = rnd_q;
    fill_d   = fill_q;
    total_d  = total_q;
    lcnt_d   = lcnt_q;
    oidx_d   = oidx_q;
    chain_d  = chain_q;
    work_d   = work_q;
    push_en  = 1'b0;
    push_val = '0;
    blk_ctrl = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            push_en  = 1'b1;
            push_val = s_axis_tdata;
            total_d  = total_inc;
          end
          if (s_axis_tlast) begin
            // The register now holds the bit length, shifted out during padding.
            total_d = {total_inc[60:0], 3'b000};
            pad_d   = 1'b1;
            phase_d = PH_MARK;
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        work_d         = round_nxt;
        blk_ctrl.shift = 1'b1;
        rnd_d          = rnd_q + 7'd1;
        if (rnd_q == 7'(LastRound)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        oidx_d     = '0;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (phase_q == PH_DONE) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        case (phase_q)
          PH_MARK: begin
            push_en  = 1'b1;
            push_val = PAD_MARK;
            phase_d  = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_q == LEN_SLOT) begin
              phase_d = PH_LEN;
              lcnt_d  = '0;
            end else begin
              push_en = 1'b1;
            end
          end
          PH_LEN: begin
            push_en  = 1'b1;
            push_val = total_q[63:56];
            total_d  = {total_q[55:0], 8'h00};
            lcnt_d   = lcnt_q + 3'd1;
            if (lcnt_q == 3'd7) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            oidx_d  = '0;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'(NumWords - 1)) begin
            for (int i = 0; i < NumWords; i++) begin
              chain_d[i] = INIT_WORDS[i];
            end
            total_d = '0;
            fill_d  = '0;
            pad_d   = 1'b0;
            phase_d = PH_MARK;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A full block starts the compression with the current chaining words.
    if (push_en) begin
      blk_ctrl.push = 1'b1;
      blk_ctrl.data = push_val;
      fill_d        = fill_q + 6'd1;
      if (fill_q == 6'd63) begin
        state_d = ST_ROUND;
        rnd_d   = '0;
        work_d  = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                    d: chain_q[3], e: chain_q[4]};
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = chain_q[oidx_q];
  assign m_axis_tuser  = oidx_q;
  assign m_axis_tlast  = (oidx_q == 3'(NumWords - 1));

endmodule

// File: hdl/sha1bsh_checker.sv
`timescale 1ns / 1ps
module sha1bsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled digest word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("digest word changed while stalled");

  // The last flag marks the fifth word and no other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
    else $error("last flag does not match word index");

  // The five words come back to back in index order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest words out of order");

  // No input is taken while a digest is being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest pending");

  // Once the last word is taken the block is ready for the next message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("block not ready after digest");

endmodule

bind sha1_byte_stream_hasher_core sha1bsh_checker u_sha1bsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
